[design/itoa_pkg.sv]
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int VALUE_FIELD_W = 64;
    localparam int ROOM_W = 8;
    localparam int CHAR_W = 8;
    localparam int LEN_W = 5;

    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W = OUT_DATA_W - CHAR_W - LEN_W;

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIGIT_BITS = NUM_DIGITS * 4;
    localparam int IDX_W = $clog2(NUM_DIGITS);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_TOO_SMALL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_SCAN,
        S_EMIT_SIGN,
        S_EMIT_DIGIT,
        S_EMIT_END
    } back_state_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic sgn;
        logic neg;
        logic [ROOM_W-1:0] room;
    } job_t;

endpackage

`default_nettype wire

[design/integer_to_decimal_ascii_core.sv]
// Channel   Fields in tdata (low bit up)        tuser        tlast
// s_axis    value[63:0], buffer_length[71:64]   is_signed    -
// m_axis    character[7:0], length[12:8]        status[1:0]  last
//
// One item is loaded, then takes VALUE_WIDTH steps of shift-and-add-3
// conversion (one bit per cycle) and a leading-zero scan; then the sign if
// signed, each digit and the terminator go out as one beat each (only the
// terminator, with an error status, if the buffer is too small or empty).
// Reset clears the state machine, the queue pointers and the output valid.
// A two-entry queue holds items accepted while the converter is busy; the
// output register is refilled in the cycle its item is taken.
`default_nettype none

module integer_to_decimal_ascii_core
    import itoa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[63:0], buffer_length[71:64]
    input  wire logic                  s_axis_tuser,   // is_signed
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // character[7:0], length[12:8], zero pad
    output logic                       m_axis_tlast,   // last
    output logic [1:0]                 m_axis_tuser    // status
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    itoa_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    itoa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    itoa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (pop_valid),
        .job_ready     (pop_ready),
        .job           (pop_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[design/itoa_front.sv]
`default_nettype none

module itoa_front
    import itoa_pkg::*;
(
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // value[63:0], buffer_length[71:64]
    input  wire logic                 s_axis_tuser,  // is_signed
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output job_t                      push_job
);

    logic [VALUE_WIDTH-1:0] value_bits;
    logic                   neg;

    always_comb
    begin
        value_bits = s_axis_tdata[VALUE_WIDTH-1:0];
        neg = s_axis_tuser & value_bits[VALUE_WIDTH-1];
        push_job.sgn = s_axis_tuser;
        push_job.neg = neg;
        push_job.room = s_axis_tdata[VALUE_FIELD_W +: ROOM_W];
        push_job.mag = neg ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;
    end

    assign push_valid = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

`default_nettype wire

[design/itoa_queue.sv]
`default_nettype none

module itoa_queue
    import itoa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid = (count_reg != '0);
        pop_job = entry_reg[rd_ptr_reg];
        do_push = push_valid & push_ready;
        do_pop = pop_valid & pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[design/itoa_back.sv]
`default_nettype none

module itoa_back
    import itoa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    input  wire job_t                  job,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // character[7:0], length[12:8], zero pad
    output logic                       m_axis_tlast,
    output logic [1:0]                 m_axis_tuser   // status
);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [DIGIT_BITS-1:0]  bcd_reg;
    logic [DIGIT_BITS-1:0]  bcd_next;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       bit_cnt_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   sgn_reg;
    logic                   sgn_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [ROOM_W-1:0]      room_reg;
    logic [ROOM_W-1:0]      room_next;
    status_t                status_reg;
    status_t                status_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg;
    logic [CHAR_W-1:0]      out_char_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    status_t                out_status_reg;
    status_t                out_status_next;
    logic [LEN_W-1:0]       out_len_reg;
    logic [LEN_W-1:0]       out_len_next;

    logic [DIGIT_BITS-1:0]  adj;
    logic [3:0]             nib;
    logic [3:0]             cur_digit;
    logic                   out_free;
    logic [LEN_W-1:0]       text_len;
    logic [ROOM_W-1:0]      need_room;

    always_comb
    begin
        nib = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            nib = bcd_reg[d*4 +: 4];
            adj[d*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_comb
    begin
        cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];
        out_free = !out_valid_reg || m_axis_tready;
        text_len = LEN_W'(idx_reg) + LEN_W'(1) + LEN_W'(sgn_reg);
        need_room = ROOM_W'(text_len) + ROOM_W'(1);

        state_next = state_reg;
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next = idx_reg;
        sgn_next = sgn_reg;
        neg_next = neg_reg;
        room_next = room_reg;
        status_next = status_reg;
        len_next = len_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_status_next = out_status_reg;
        out_len_next = out_len_reg;
        job_ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    mag_next = job.mag;
                    sgn_next = job.sgn;
                    neg_next = job.neg;
                    room_next = job.room;
                    bcd_next = '0;
                    bit_cnt_next = CNT_W'(VALUE_WIDTH - 1);
                    state_next = S_CONVERT;
                end
            end
            S_CONVERT:
            begin
                bcd_next = {adj[DIGIT_BITS-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    idx_next = IDX_W'(NUM_DIGITS - 1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cur_digit == 4'd0 && idx_reg != '0)
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
                else if (room_reg == '0)
                begin
                    status_next = ST_NO_ROOM;
                    len_next = '0;
                    state_next = S_EMIT_END;
                end
                else if (room_reg < need_room)
                begin
                    status_next = ST_TOO_SMALL;
                    len_next = '0;
                    state_next = S_EMIT_END;
                end
                else
                begin
                    status_next = ST_OK;
                    len_next = text_len;
                    state_next = sgn_reg ? S_EMIT_SIGN : S_EMIT_DIGIT;
                end
            end
            S_EMIT_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next = neg_reg ? CHAR_MINUS : CHAR_SPACE;
                    out_last_next = 1'b0;
                    out_status_next = ST_OK;
                    out_len_next = '0;
                    state_next = S_EMIT_DIGIT;
                end
            end
            S_EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next = CHAR_ZERO + CHAR_W'(cur_digit);
                    out_last_next = 1'b0;
                    out_status_next = ST_OK;
                    out_len_next = '0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_EMIT_END;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            S_EMIT_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next = CHAR_NUL;
                    out_last_next = 1'b1;
                    out_status_next = status_reg;
                    out_len_next = len_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        idx_reg <= idx_next;
        sgn_reg <= sgn_next;
        neg_reg <= neg_next;
        room_reg <= room_next;
        status_reg <= status_next;
        len_reg <= len_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_status_reg <= out_status_next;
        out_len_reg <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {OUT_PAD_W'(0), out_len_reg, out_char_reg};
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_status_reg;

endmodule

`default_nettype wire

[tb/sv/integer_to_decimal_ascii_core_tb.sv]
`default_nettype none

module integer_to_decimal_ascii_core_tb;
    import itoa_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_NUMBERS = 320;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 50;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    typedef logic [CHAR_W-1:0] text_t[$];

    typedef struct {
        logic [63:0]       value;
        logic              is_signed;
        logic [ROOM_W-1:0] room;
        int                gap;
    } number_item_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        status_t           status;
        logic [LEN_W-1:0]  len;
    } char_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value[63:0], buffer_length[71:64]
    logic                  s_axis_tuser = 1'b0; // is_signed
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // character[7:0], length[12:8], zero pad
    logic                  m_axis_tlast;        // last
    logic [1:0]            m_axis_tuser;        // status

    number_item_t pending_numbers[$];
    number_item_t cur_number;
    char_item_t   expected_chars[$];
    int           mismatch_count = 0;
    int           src_gap_left = 0;
    bit           src_busy;
    bit           src_calm = 1'b0;
    int           sink_wait = 0;
    bit           sink_ready;
    bit           sink_calm = 1'b0;
    int           idle_cycles = 0;

    integer_to_decimal_ascii_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic text_t decimal_text(input logic [63:0] raw, input logic sgn);
        logic [63:0] v;
        logic [63:0] mag;
        logic        neg;
        text_t       t;
        v = raw & VALUE_MASK;
        neg = sgn && v[VALUE_WIDTH-1];
        mag = neg ? ((64'd0 - v) & VALUE_MASK) : v;
        do
        begin
            t.push_front(CHAR_ZERO + CHAR_W'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);
        if (sgn)
        begin
            t.push_front(neg ? CHAR_MINUS : CHAR_SPACE);
        end
        return t;
    endfunction

    task automatic predict_text(input number_item_t n);
        text_t      t;
        char_item_t c;
        t = decimal_text(n.value, n.is_signed);
        c.last = 1'b0;
        c.len = '0;
        if (n.room == 0)
        begin
            expected_chars.push_back('{CHAR_NUL, 1'b1, ST_NO_ROOM, '0});
        end
        else if (int'(n.room) < t.size() + 1)
        begin
            expected_chars.push_back('{CHAR_NUL, 1'b1, ST_TOO_SMALL, '0});
        end
        else
        begin
            foreach (t[i])
            begin
                c.ch = t[i];
                c.status = ST_OK;
                expected_chars.push_back(c);
            end
            expected_chars.push_back('{CHAR_NUL, 1'b1, ST_OK, LEN_W'(t.size())});
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH: %s", msg);
        end
        mismatch_count++;
    endtask

    task automatic add_number(input logic [63:0] v, input logic sgn, input int room);
        number_item_t n;
        n.value = v;
        n.is_signed = sgn;
        n.room = ROOM_W'(room);
        n.gap = src_calm ? 0 : $urandom_range(0, 10);
        pending_numbers.push_back(n);
    endtask

    // driver: hold the item until taken, then wait the next item's gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            src_gap_left = 0;
        end
        else
        begin
            src_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text(cur_number);
                src_busy = 1'b0;
                src_gap_left = (pending_numbers.size() > 0) ? pending_numbers[0].gap : 0;
            end
            if (!src_busy)
            begin
                if (src_gap_left > 0)
                begin
                    src_gap_left--;
                end
                else if (pending_numbers.size() > 0)
                begin
                    cur_number = pending_numbers.pop_front();
                    s_axis_tdata <= {cur_number.room, cur_number.value};
                    s_axis_tuser <= cur_number.is_signed;
                    src_busy = 1'b1;
                end
            end
            s_axis_tvalid <= src_busy;
        end
    end

    // monitor: check each taken item, then may stall before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            sink_ready = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %02h last %0b status %0d len %0d",
                        m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser, m_axis_tdata[12:8]));
                end
                else if (m_axis_tdata[CHAR_W-1:0] !== expected_chars[0].ch
                    || m_axis_tlast !== expected_chars[0].last
                    || m_axis_tuser !== expected_chars[0].status
                    || m_axis_tdata[CHAR_W+LEN_W-1:CHAR_W] !== expected_chars[0].len)
                begin
                    report_mismatch($sformatf(
                        "char %02h/%02h last %0b/%0b status %0d/%0d len %0d/%0d (got/exp)",
                        m_axis_tdata[7:0], expected_chars[0].ch,
                        m_axis_tlast, expected_chars[0].last,
                        m_axis_tuser, expected_chars[0].status,
                        m_axis_tdata[12:8], expected_chars[0].len));
                end
                if (expected_chars.size() > 0)
                begin
                    void'(expected_chars.pop_front());
                end
                if ($urandom_range(0, 29) == 0)
                begin
                    sink_calm = ~sink_calm;
                end
                sink_ready = 1'b0;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
            end
            if (!sink_ready)
            begin
                if (sink_wait > 0)
                begin
                    sink_wait--;
                end
                else
                begin
                    sink_ready = 1'b1;
                end
            end
            m_axis_tready <= sink_ready;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [63:0] v;
        logic [63:0] p;
        logic        sgn;
        int          tl;
        int          room;
        text_t       tt;

        add_number(64'd0, 1'b0, 2);
        add_number(64'd0, 1'b1, 3);
        add_number(64'd0, 1'b0, 1);
        add_number(64'd0, 1'b0, 0);
        add_number(64'd5, 1'b1, 0);
        add_number({64{1'b1}}, 1'b0, 21);
        add_number({64{1'b1}}, 1'b0, 20);
        add_number({64{1'b1}}, 1'b0, 255);
        add_number({64{1'b1}}, 1'b1, 3);
        add_number({64{1'b1}}, 1'b1, 2);
        add_number({1'b1, 63'd0}, 1'b1, 21);
        add_number({1'b1, 63'd0}, 1'b1, 20);
        add_number({1'b1, 63'd0}, 1'b0, 255);
        add_number({1'b0, {63{1'b1}}}, 1'b1, 255);
        add_number({1'b0, {63{1'b1}}}, 1'b0, 20);
        add_number(64'd9, 1'b0, 2);
        add_number(64'd10, 1'b0, 3);
        add_number(64'd99, 1'b1, 4);
        add_number(64'd100, 1'b1, 4);
        add_number(64'd1234567890, 1'b0, 11);
        add_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, 4);
        add_number(64'h5555_5555_AAAA_AAAA, 1'b0, 255);

        for (int k = 0; k < RANDOM_NUMBERS; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = {$urandom, $urandom};
                4, 5:       v = 64'($urandom_range(0, 1000));
                6:          v = {$urandom, $urandom} >> $urandom_range(0, 63);
                7:
                begin
                    p = 64'd1;
                    repeat ($urandom_range(0, 19)) p = p * 64'd10;
                    v = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
                8:          v = 64'd0 - 64'($urandom_range(1, 1000));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = {1'b1, 63'd0};
                        1:       v = {64{1'b1}};
                        2:       v = {1'b0, {63{1'b1}}};
                        default: v = 64'd0;
                    endcase
                end
            endcase
            sgn = 1'($urandom_range(0, 1));
            tt = decimal_text(v, sgn);
            tl = tt.size();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: room = tl + 1 + $urandom_range(0, 3);
                6:                room = tl + 1;
                7:                room = tl;
                8:                room = $urandom_range(0, 255);
                default:          room = $urandom_range(0, 1) ? 255 : 0;
            endcase
            if ($urandom_range(0, 39) == 0)
            begin
                src_calm = ~src_calm;
            end
            add_number(v, sgn, room);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() > 0 || s_axis_tvalid || expected_chars.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_queue.sv
design/itoa_back.sv
design/integer_to_decimal_ascii_core.sv
tb/sv/integer_to_decimal_ascii_core_tb.sv
